### hdl/m4m_pkg.sv
// Shared types and constants for the 4x4 matrix multiply unit.
package m4m_pkg;

   localparam int DIM         = 4;
   localparam int IDX_W       = 2;
   localparam int ADDR_W      = 2 * IDX_W;
   localparam int STEP_W      = 3 * IDX_W;
   localparam int ELEM_W      = 32;
   localparam int FRAC_W      = 16;
   localparam int PROD_W      = 2 * ELEM_W;
   localparam int TERM_W      = PROD_W - FRAC_W;
   localparam int ACC_W       = TERM_W + 2;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [1:0] FUNC_WRITE_LEFT  = 2'd0;
   localparam logic [1:0] FUNC_WRITE_RIGHT = 2'd1;
   localparam logic [1:0] FUNC_COMPUTE     = 2'd2;

   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DIM - 1);

   localparam logic signed [ELEM_W-1:0] Q_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
   localparam logic signed [ELEM_W-1:0] Q_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

   typedef struct packed {
      logic [1:0]               func;
      logic [IDX_W-1:0]         outer;
      logic [IDX_W-1:0]         inner;
      logic signed [ELEM_W-1:0] value;
   } req_type;

endpackage

### hdl/m4m_front.sv
// Request intake: drops unused codes and queues requests for the back end.
module m4m_front import m4m_pkg::*; #(
   parameter int QueueDepth = QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_func,
   input  logic [IDX_W-1:0]         req_outer_index,
   input  logic [IDX_W-1:0]         req_inner_index,
   input  logic signed [ELEM_W-1:0] req_element_value,
   output logic                     head_valid,
   output req_type                  head,
   input  logic                     pop
);

   localparam int PTR_W = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CNT_W = $clog2(QueueDepth + 1);

   req_type              queue_ff [QueueDepth];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 accept;
   logic                 push;
   logic                 do_pop;

   assign req_stall  = (count_ff == CNT_W'(QueueDepth));
   assign accept     = req_valid && !req_stall;
   assign head_valid = (count_ff != '0);
   assign head       = queue_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      push = accept &&
             (req_func inside {FUNC_WRITE_LEFT, FUNC_WRITE_RIGHT, FUNC_COMPUTE});
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= '{func:  req_func,
                                  outer: req_outer_index,
                                  inner: req_inner_index,
                                  value: req_element_value};
      end
   end

endmodule

### hdl/m4m_back.sv
// Execution: matrix storage, multiply-accumulate pipeline and result register.
module m4m_back import m4m_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     head_valid,
   input  req_type                  head,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [IDX_W-1:0]         rsp_out_outer,
   output logic [IDX_W-1:0]         rsp_out_inner,
   output logic signed [ELEM_W-1:0] rsp_product_value,
   output logic                     rsp_saturated,
   output logic                     rsp_last
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_BUSY = 1'b1;

   logic signed [ELEM_W-1:0] left_mem  [DIM*DIM];
   logic signed [ELEM_W-1:0] right_mem [DIM*DIM];

   logic                     state_ff, state_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic                     advance;
   logic                     issue;
   logic [IDX_W-1:0]         st_m, st_c, st_r;

   logic                     s1_valid_ff;
   logic [STEP_W-1:0]        s1_step_ff;
   logic signed [ELEM_W-1:0] left_rd_ff, right_rd_ff;

   logic                     s2_valid_ff;
   logic [STEP_W-1:0]        s2_step_ff;
   logic signed [PROD_W-1:0] prod_ff;

   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  term;
   logic signed [ACC_W-1:0]  sum;
   logic [ACC_W-ELEM_W:0]    upper;
   logic                     sat;
   logic [IDX_W-1:0]         s2_m, s2_c, s2_r;

   logic                     rsp_valid_ff;
   logic [IDX_W-1:0]         rsp_outer_ff, rsp_inner_ff;
   logic signed [ELEM_W-1:0] rsp_value_ff;
   logic                     rsp_sat_ff, rsp_last_ff;

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign pop     = head_valid && (state_ff == ST_IDLE);
   assign issue   = (state_ff == ST_BUSY) && advance;
   assign {st_m, st_c, st_r} = step_ff;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop && head.func == FUNC_COMPUTE) begin
               state_in = ST_BUSY;
               step_in  = '0;
            end
         end
         ST_BUSY: begin
            if (issue) begin
               step_in = step_ff + 1'b1;
               if (step_ff == '1) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && head.func == FUNC_WRITE_LEFT) begin
         left_mem[{head.outer, head.inner}] <= head.value;
      end
      if (pop && head.func == FUNC_WRITE_RIGHT) begin
         right_mem[{head.outer, head.inner}] <= head.value;
      end
   end

   // stage 1: operand fetch
   always_ff @(posedge clock) begin
      if (issue) begin
         left_rd_ff  <= left_mem[{st_m, st_r}];
         right_rd_ff <= right_mem[{st_r, st_c}];
         s1_step_ff  <= step_ff;
      end
   end

   // stage 2: product
   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff    <= left_rd_ff * right_rd_ff;
         s2_step_ff <= s1_step_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= issue;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // stage 3: accumulate, clamp
   always_comb begin
      {s2_m, s2_c, s2_r} = s2_step_ff;
      term  = {{(ACC_W-TERM_W){prod_ff[PROD_W-1]}}, prod_ff[PROD_W-1:FRAC_W]};
      sum   = ((s2_r == '0) ? '0 : acc_ff) + term;
      upper = sum[ACC_W-1:ELEM_W-1];
      sat   = !((&upper) || !(|upper));
   end

   always_ff @(posedge clock) begin
      if (advance && s2_valid_ff) begin
         acc_ff <= sum;
      end
      if (advance && s2_valid_ff && s2_r == IDX_LAST) begin
         rsp_outer_ff <= s2_m;
         rsp_inner_ff <= s2_c;
         rsp_value_ff <= sat ? (sum[ACC_W-1] ? Q_MIN : Q_MAX) : sum[ELEM_W-1:0];
         rsp_sat_ff   <= sat;
         rsp_last_ff  <= (s2_m == IDX_LAST) && (s2_c == IDX_LAST);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s2_valid_ff && (s2_r == IDX_LAST);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_outer     = rsp_outer_ff;
   assign rsp_out_inner     = rsp_inner_ff;
   assign rsp_product_value = rsp_value_ff;
   assign rsp_saturated     = rsp_sat_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

### hdl/matrix4x4_multiply_unit.sv
// Top level of the 4x4 Q16.16 matrix multiply unit.
//
// Request channel (req_*): func 0 writes left[outer][inner], func 1 writes
// right[outer][inner], func 2 computes left x right, func 3 is dropped.
// Requests enter a small queue; req_stall rises only while it is full.
// Response channel (rsp_*): a compute gives sixteen responses in row-major
// order, rsp_last on the final one. Sums of Q16.16 products are clamped to
// 32 bits with rsp_saturated set when clamping occurs.
// Throughput: one write per cycle while no compute is in progress; a
// compute issues one multiply-accumulate per cycle unless rsp_stall holds
// a pending response, on a single multiplier fed by one read port per
// matrix, giving one response per four multiply-accumulates.
// rsp_stall, while a response is pending, freezes the whole execution
// pipeline; the queue keeps taking requests until full. Reset empties the
// queue and pipeline; matrix contents are undefined until written.
module matrix4x4_multiply_unit import m4m_pkg::*; #(
   parameter int QueueDepth = QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_func,
   input  logic [IDX_W-1:0]         req_outer_index,
   input  logic [IDX_W-1:0]         req_inner_index,
   input  logic signed [ELEM_W-1:0] req_element_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [IDX_W-1:0]         rsp_out_outer,
   output logic [IDX_W-1:0]         rsp_out_inner,
   output logic signed [ELEM_W-1:0] rsp_product_value,
   output logic                     rsp_saturated,
   output logic                     rsp_last
);

   logic    head_valid;
   req_type head;
   logic    pop;

   m4m_front #(
      .QueueDepth(QueueDepth)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_outer_index   (req_outer_index),
      .req_inner_index   (req_inner_index),
      .req_element_value (req_element_value),
      .head_valid        (head_valid),
      .head              (head),
      .pop               (pop)
   );

   m4m_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (head_valid),
      .head              (head),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_outer     (rsp_out_outer),
      .rsp_out_inner     (rsp_out_inner),
      .rsp_product_value (rsp_product_value),
      .rsp_saturated     (rsp_saturated),
      .rsp_last          (rsp_last)
   );

   assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue popped while empty");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_out_outer == IDX_LAST && rsp_out_inner == IDX_LAST)
      else $error("last flag on wrong element");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> rsp_product_value == Q_MAX || rsp_product_value == Q_MIN)
      else $error("saturated response not clamped");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_product_value))
      else $error("stalled response changed");

endmodule
